>>> design/assert_macros.svh
// Concurrent assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define LFS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds through reset.
`define LFS_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> design/lfs_pkg.sv
package lfs_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_MAX_OUT     = 64;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_QUEUE   = 2'd1;
    localparam logic [1:0] CMD_COLLECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SEL = 2'd3;

    localparam logic [6:0]  MAX_SEL_RESET = 7'd64;
    localparam logic [16:0] ONE_Q16       = 17'h10000;
    localparam logic [19:0] DIST_MAX      = 20'hFFFFF;
    localparam logic [17:0] THREE_Q16     = 18'd196608;

    typedef struct packed {
        logic [1:0]         command;
        logic [15:0]        entity_id;
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic signed [19:0] pos_z;
        logic [13:0]        light_radius;
        logic [15:0]        base_intensity;
        logic [19:0]        fade_near;
        logic [19:0]        fade_far;
        logic [15:0]        style_weight;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  light_slot;
        logic [31:0] weighted_intensity;
        logic [19:0] view_distance;
        logic        none_found;
        logic        last_result;
    } t_out_item;

    typedef struct packed {
        logic [19:0] pos_x;
        logic [19:0] pos_y;
        logic [19:0] pos_z;
        logic [19:0] near;
        logic [19:0] far;
        logic [15:0] inten;
        logic [15:0] style;
        logic [15:0] owner;
    } t_light;

endpackage

>>> design/light_fade_top_k_selector.sv
// Light table with ranked collect. Clear only resets the light count. A queue of a light
// with nonzero radius and intensity first searches the stored lights (up to TABLE_DEPTH)
// for a matching owner when the entity is nonzero, then writes the table. Collect walks the
// table through one light memory port: a light with a fade takes the 21-step square root
// and may take the 16-step divider, which a light whose fade is disabled skips. It then
// makes one pass over the key memory per selected light, each over the n weighted lights,
// and an emit waits while the output is stalled. No new item is taken until a command is
// finished. Table stores need no clearing pass.
module light_fade_top_k_selector #(
    parameter int TABLE_DEPTH = lfs_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_OUT     = lfs_pkg::DEF_MAX_OUT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lfs_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lfs_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lfs_pkg::CFG_W-1:0]       i_cfg_data
);
    import lfs_pkg::*;

    localparam int SW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = 52 + SW;
    localparam logic [6:0]    MAX_OUT_C = 7'(MAX_OUT);
    localparam logic [CW-1:0] DEPTH_C   = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_Q_SCAN, S_Q_WR,
        S_C_RD, S_C_LOAD, S_C_SQ, S_C_SUM, S_C_SQRT, S_C_FADE, S_C_DIV,
        S_C_SM1, S_C_SM2, S_C_W1, S_C_W2,
        S_S_START, S_S_SCAN, S_S_EMIT, S_M_EMIT
    } t_state;

    t_state          r_state;
    logic [19:0]     r_view_x, r_view_y, r_view_z;
    logic [6:0]      r_max_sel;
    logic [CW-1:0]   r_count, r_n, r_idx, r_pidx, r_slot, r_j;
    logic            r_pend, r_have;
    t_in_item        r_item;

    t_light          m_tab [TABLE_DEPTH];
    t_light          r_tab_q;
    logic [KW-1:0]   m_key [TABLE_DEPTH];
    logic [KW-1:0]   r_key_q;

    logic [19:0]     r_near, r_far, r_den, r_dist;
    logic [15:0]     r_inten, r_style, r_q;
    logic [20:0]     r_ax, r_ay, r_az, r_root, r_drem;
    logic [41:0]     r_sqx, r_sqy, r_sqz, r_sq_n;
    logic [24:0]     r_rem;
    logic [4:0]      r_cnt;
    logic [31:0]     r_tt, r_pw;
    logic [17:0]     r_k;
    logic [16:0]     r_fade;

    logic [6:0]      r_limit, r_k_out;
    logic [KW-1:0]   r_best, r_last;

    logic            r_out_valid;
    t_out_item       r_out;

    logic            w_accept, w_out_free, w_swap, w_tab_we, w_key_we, w_sq_ge, w_div_ge;
    logic            w_emit;
    t_light          w_tab_wdata;
    logic [24:0]     w_rem2, w_trial;
    logic [20:0]     w_drem2;
    logic [49:0]     w_prod_sm;
    logic [48:0]     w_prod_w;
    logic [31:0]     w_weight;
    logic [19:0]     w_d;
    logic [6:0]      w_lim0;

    function automatic logic [20:0] abs_diff(input logic [19:0] a, input logic [19:0] b);
        logic [20:0] d;
        d = {a[19], a} - {b[19], b};
        return d[20] ? (21'd0 - d) : d;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = w_out_free && (r_state == S_S_EMIT || r_state == S_M_EMIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_rem2   = {r_rem[22:0], r_sq_n[41:40]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_sq_ge  = (w_rem2 >= w_trial);
    assign w_drem2  = {r_drem[19:0], 1'b0};
    assign w_div_ge = (w_drem2 >= {1'b0, r_den});
    assign w_prod_sm = 50'(r_tt) * 50'(r_k);
    assign w_prod_w  = 49'(r_pw) * 49'(r_fade);
    assign w_weight  = 32'(w_prod_w[48:22]);
    assign w_d       = r_root[20] ? DIST_MAX : r_root[19:0];
    assign w_lim0    = (r_max_sel > MAX_OUT_C) ? MAX_OUT_C : r_max_sel;

    assign w_tab_we = (r_state == S_Q_WR) && (r_slot < DEPTH_C);
    assign w_key_we = (r_state == S_C_W2) && (w_weight != 32'd0);

    always_comb begin
        w_swap = (r_item.fade_far != 20'd0) && (r_item.fade_near > r_item.fade_far);
        w_tab_wdata.pos_x = r_item.pos_x;
        w_tab_wdata.pos_y = r_item.pos_y;
        w_tab_wdata.pos_z = r_item.pos_z;
        w_tab_wdata.near  = w_swap ? r_item.fade_far : r_item.fade_near;
        w_tab_wdata.far   = w_swap ? r_item.fade_near : r_item.fade_far;
        w_tab_wdata.inten = r_item.base_intensity;
        w_tab_wdata.style = r_item.style_weight;
        w_tab_wdata.owner = r_item.entity_id;
    end

    always_ff @(posedge i_clk) begin
        if (w_tab_we) begin
            m_tab[r_slot[SW-1:0]] <= w_tab_wdata;
        end
        r_tab_q <= m_tab[r_idx[SW-1:0]];
        if (w_key_we) begin
            m_key[r_n[SW-1:0]] <= {~w_weight, r_dist, r_idx[SW-1:0]};
        end
        r_key_q <= m_key[r_j[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_view_z    <= '0;
            r_max_sel   <= MAX_SEL_RESET;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_VIEW_X:  r_view_x  <= i_cfg_data;
                    REG_VIEW_Y:  r_view_y  <= i_cfg_data;
                    REG_VIEW_Z:  r_view_z  <= i_cfg_data;
                    REG_MAX_SEL: r_max_sel <= i_cfg_data[6:0];
                endcase
            end

            if (r_out_valid && !i_out_stall && !w_emit) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_item <= i_in_data;
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        r_slot <= r_count;
                        priority if (i_in_data.command == CMD_CLEAR) begin
                            r_count <= '0;
                        end else if (i_in_data.command == CMD_QUEUE) begin
                            if (i_in_data.light_radius != 14'd0
                                    && i_in_data.base_intensity != 16'd0) begin
                                r_state <= (i_in_data.entity_id != 16'd0) ? S_Q_SCAN : S_Q_WR;
                            end
                        end else if (i_in_data.command == CMD_COLLECT) begin
                            r_n     <= '0;
                            r_state <= S_C_RD;
                        end
                    end
                end
                S_Q_SCAN: begin
                    priority if (r_pend && r_tab_q.owner == r_item.entity_id) begin
                        r_slot  <= r_pidx;
                        r_pend  <= 1'b0;
                        r_state <= S_Q_WR;
                    end else if (r_idx < r_count) begin
                        r_pidx <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_Q_WR;
                    end
                end
                S_Q_WR: begin
                    if (r_slot < DEPTH_C && r_slot == r_count) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_C_RD: begin
                    r_state <= (r_idx < r_count) ? S_C_LOAD : S_S_START;
                end
                S_C_LOAD: begin
                    r_near  <= r_tab_q.near;
                    r_far   <= r_tab_q.far;
                    r_inten <= r_tab_q.inten;
                    r_style <= r_tab_q.style;
                    r_ax    <= abs_diff(r_tab_q.pos_x, r_view_x);
                    r_ay    <= abs_diff(r_tab_q.pos_y, r_view_y);
                    r_az    <= abs_diff(r_tab_q.pos_z, r_view_z);
                    if ((r_tab_q.near <= 20'd1 && r_tab_q.far <= 20'd1)
                            || r_tab_q.far == 20'd0) begin
                        r_dist  <= '0;
                        r_fade  <= ONE_Q16;
                        r_state <= S_C_W1;
                    end else begin
                        r_state <= S_C_SQ;
                    end
                end
                S_C_SQ: begin
                    r_sqx   <= 42'(r_ax) * 42'(r_ax);
                    r_sqy   <= 42'(r_ay) * 42'(r_ay);
                    r_sqz   <= 42'(r_az) * 42'(r_az);
                    r_state <= S_C_SUM;
                end
                S_C_SUM: begin
                    r_sq_n  <= r_sqx + r_sqy + r_sqz;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_C_SQRT;
                end
                S_C_SQRT: begin
                    r_rem  <= w_sq_ge ? (w_rem2 - w_trial) : w_rem2;
                    r_root <= {r_root[19:0], w_sq_ge};
                    r_sq_n <= {r_sq_n[39:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'd20) begin
                        r_state <= S_C_FADE;
                    end
                end
                S_C_FADE: begin
                    r_dist <= w_d;
                    priority if (r_near > r_far) begin
                        r_fade  <= ONE_Q16;
                        r_state <= S_C_W1;
                    end else if (w_d >= r_far) begin
                        r_fade  <= (r_near == 20'd0) ? ONE_Q16 : 17'd0;
                        r_state <= S_C_W1;
                    end else if (r_near != 20'd0 && w_d <= r_near) begin
                        r_fade  <= ONE_Q16;
                        r_state <= S_C_W1;
                    end else begin
                        r_drem  <= 21'(w_d - r_near);
                        r_den   <= r_far - r_near;
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= S_C_DIV;
                    end
                end
                S_C_DIV: begin
                    r_drem <= w_div_ge ? (w_drem2 - {1'b0, r_den}) : w_drem2;
                    r_q    <= {r_q[14:0], w_div_ge};
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_C_SM1;
                    end
                end
                S_C_SM1: begin
                    if (r_near == 20'd0) begin
                        r_fade  <= {1'b0, r_q};
                        r_state <= S_C_W1;
                    end else begin
                        r_tt    <= 32'(r_q) * 32'(r_q);
                        r_k     <= THREE_Q16 - {1'b0, r_q, 1'b0};
                        r_state <= S_C_SM2;
                    end
                end
                S_C_SM2: begin
                    r_fade  <= ONE_Q16 - w_prod_sm[48:32];
                    r_state <= S_C_W1;
                end
                S_C_W1: begin
                    r_pw    <= 32'(r_inten) * 32'(r_style);
                    r_state <= S_C_W2;
                end
                S_C_W2: begin
                    if (w_key_we) begin
                        r_n <= r_n + 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_C_RD;
                end
                S_S_START: begin
                    r_k_out <= '0;
                    r_j     <= '0;
                    r_pend  <= 1'b0;
                    r_have  <= 1'b0;
                    r_limit <= (32'(r_n) < 32'(w_lim0)) ? 7'(r_n) : w_lim0;
                    if (r_n == '0 || r_max_sel == 7'd0) begin
                        r_state <= S_M_EMIT;
                    end else begin
                        r_state <= S_S_SCAN;
                    end
                end
                S_S_SCAN: begin
                    if (r_pend && (r_k_out == 7'd0 || r_key_q > r_last)
                            && (!r_have || r_key_q < r_best)) begin
                        r_best <= r_key_q;
                        r_have <= 1'b1;
                    end
                    if (r_j < r_n) begin
                        r_j    <= r_j + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_state <= S_S_EMIT;
                        end
                    end
                end
                S_S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out.light_slot         <= 8'(r_best[SW-1:0]);
                        r_out.weighted_intensity <= ~r_best[KW-1 -: 32];
                        r_out.view_distance      <= r_best[SW +: 20];
                        r_out.none_found         <= 1'b0;
                        r_out.last_result        <= (7'(r_k_out + 7'd1) == r_limit);
                        r_last  <= r_best;
                        r_k_out <= r_k_out + 7'd1;
                        r_j     <= '0;
                        r_pend  <= 1'b0;
                        r_have  <= 1'b0;
                        r_state <= (7'(r_k_out + 7'd1) == r_limit) ? S_IDLE : S_S_SCAN;
                    end
                end
                S_M_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid              <= 1'b1;
                        r_out.light_slot         <= '0;
                        r_out.weighted_intensity <= '0;
                        r_out.view_distance      <= '0;
                        r_out.none_found         <= 1'b1;
                        r_out.last_result        <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> design/lfs_checker.sv
`include "assert_macros.svh"

module lfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input lfs_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input lfs_pkg::t_out_item o_out_data
);
    import lfs_pkg::*;

    `LFS_ASSERT_NR(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)
    `LFS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
    `LFS_ASSERT(a_marker_last, i_clk, i_rst_n, o_out_valid && o_out_data.none_found |-> o_out_data.last_result && o_out_data.weighted_intensity == 32'd0)
    `LFS_ASSERT(a_weight_pos, i_clk, i_rst_n, o_out_valid && !o_out_data.none_found |-> o_out_data.weighted_intensity != 32'd0)
    `LFS_ASSERT(a_busy_collect, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_in_data.command == CMD_COLLECT |=> o_in_stall)

endmodule

bind light_fade_top_k_selector lfs_checker u_lfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

>>> tb/tb_light_fade_top_k_selector.sv
module tb_light_fade_top_k_selector;
    import lfs_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int MAXO = DEF_MAX_OUT;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE = 400;
    localparam int IN_W = $bits(t_in_item);

    logic i_clk;
    logic i_rst_n;
    logic in_valid;
    logic in_stall;
    t_in_item in_data;
    logic out_valid;
    logic out_stall;
    t_out_item out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    light_fade_top_k_selector uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in_data(in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data(out_data),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    // predictor state
    t_light lights[DEPTH];
    int light_total;
    logic [19:0] viewer[3];
    logic [6:0] select_limit;

    t_out_item ranked_q[$];
    int errors;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int sent;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200000000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned distance_of(t_light l);
        longint d[3];
        longint unsigned sum;
        longint unsigned r;
        d[0] = longint'($signed(l.pos_x)) - longint'($signed(viewer[0]));
        d[1] = longint'($signed(l.pos_y)) - longint'($signed(viewer[1]));
        d[2] = longint'($signed(l.pos_z)) - longint'($signed(viewer[2]));
        sum = 0;
        for (int k = 0; k < 3; k++) sum += longint'(d[k] * d[k]);
        r = int_sqrt(sum);
        return (r > 64'd1048575) ? 64'd1048575 : r;
    endfunction

    function automatic longint unsigned fade_of(t_light l, output longint unsigned vdist);
        longint unsigned nr;
        longint unsigned fr;
        longint unsigned frac;
        longint unsigned t;
        longint unsigned smooth;
        nr = l.near;
        fr = l.far;
        vdist = 0;
        if (nr <= 1 && fr <= 1) return 65536;
        if (fr == 0) return 65536;
        vdist = distance_of(l);
        if (nr > fr) return 65536;
        frac = (vdist >= fr) ? 65536 : (vdist << 16) / fr;
        if (nr == 0) return frac;
        if (vdist >= fr) t = 65536;
        else if (vdist <= nr) t = 0;
        else t = ((vdist - nr) << 16) / (fr - nr);
        smooth = (t * t * (3 * 65536 - 2 * t)) >> 32;
        return 65536 - smooth;
    endfunction

    task automatic rank_lights();
        longint unsigned keys[$];
        longint unsigned vdist;
        longint unsigned fd;
        longint unsigned w;
        int limit;
        t_out_item r;
        limit = (select_limit > MAXO) ? MAXO : int'(select_limit);
        for (int i = 0; i < light_total; i++) begin
            fd = fade_of(lights[i], vdist);
            w = (longint'(lights[i].inten) * longint'(lights[i].style) * fd) >> 22;
            if (w > 64'hFFFFFFFF) w = 64'hFFFFFFFF;
            if (w != 0)
                keys = {keys, ((64'hFFFFFFFF - w) << 32) | (vdist << 12) | longint'(i)};
        end
        if (keys.size() == 0 || limit == 0) begin
            r = '0;
            r.none_found = 1'b1;
            r.last_result = 1'b1;
            ranked_q = {ranked_q, r};
            return;
        end
        keys.sort();
        if (limit > keys.size()) limit = keys.size();
        for (int k = 0; k < limit; k++) begin
            r.light_slot = keys[k][7:0];
            r.weighted_intensity = 32'hFFFFFFFF - keys[k][63:32];
            r.view_distance = keys[k][31:12];
            r.none_found = 1'b0;
            r.last_result = (k + 1 == limit);
            ranked_q = {ranked_q, r};
        end
    endtask

    task automatic store_light(t_in_item it);
        int slot;
        logic [19:0] nr;
        logic [19:0] fr;
        if (it.light_radius == 0 || it.base_intensity == 0) return;
        nr = it.fade_near;
        fr = it.fade_far;
        if (fr > 0 && nr > fr) begin
            nr = it.fade_far;
            fr = it.fade_near;
        end
        slot = light_total;
        if (it.entity_id != 0)
            for (int i = 0; i < light_total; i++)
                if (lights[i].owner == it.entity_id) begin
                    slot = i;
                    break;
                end
        if (slot >= DEPTH) return;
        lights[slot].pos_x = it.pos_x;
        lights[slot].pos_y = it.pos_y;
        lights[slot].pos_z = it.pos_z;
        lights[slot].near = nr;
        lights[slot].far = fr;
        lights[slot].inten = it.base_intensity;
        lights[slot].style = it.style_weight;
        lights[slot].owner = it.entity_id;
        if (slot == light_total) light_total++;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h", what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && out_valid && !out_stall) begin
            if (ranked_q.size() == 0) begin
                report("unexpected transfer", 32'(out_data.light_slot), 32'd0);
            end else begin
                e = ranked_q.pop_front();
                if (out_data.light_slot !== e.light_slot)
                    report("light_slot", 32'(out_data.light_slot), 32'(e.light_slot));
                if (out_data.weighted_intensity !== e.weighted_intensity)
                    report("weighted_intensity", out_data.weighted_intensity,
                           e.weighted_intensity);
                if (out_data.view_distance !== e.view_distance)
                    report("view_distance", 32'(out_data.view_distance),
                           32'(e.view_distance));
                if (out_data.none_found !== e.none_found)
                    report("none_found", 32'(out_data.none_found), 32'(e.none_found));
                if (out_data.last_result !== e.last_result)
                    report("last_result", 32'(out_data.last_result), 32'(e.last_result));
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sent++;
        case (it.command)
            CMD_CLEAR: light_total = 0;
            CMD_QUEUE: store_light(it);
            CMD_COLLECT: rank_lights();
            default: ;
        endcase
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (ranked_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_MAX_SEL) select_limit = val[6:0];
        else viewer[idx] = val;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_cmd(logic [1:0] c);
        t_in_item it;
        it = '0;
        it.command = c;
        return it;
    endfunction

    function automatic t_in_item make_light(logic [15:0] owner, int fade_kind);
        t_in_item it;
        it.command = CMD_QUEUE;
        it.entity_id = owner;
        if ($urandom_range(4) == 0) begin
            it.pos_x = 20'($urandom);
            it.pos_y = 20'($urandom);
            it.pos_z = 20'($urandom);
        end else begin
            it.pos_x = viewer[0] + 20'($urandom_range(4000)) - 20'd2000;
            it.pos_y = viewer[1] + 20'($urandom_range(4000)) - 20'd2000;
            it.pos_z = viewer[2] + 20'($urandom_range(4000)) - 20'd2000;
        end
        it.light_radius = ($urandom_range(19) == 0) ? 14'd0 : 14'($urandom);
        it.base_intensity = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
        it.style_weight = ($urandom_range(2) == 0) ? 16'd16384 : 16'($urandom);
        case (fade_kind)
            0: begin
                it.fade_near = 20'($urandom);
                it.fade_far = 20'($urandom);
            end
            1: begin
                it.fade_far = 20'($urandom_range(1));
                it.fade_near = 20'($urandom_range(1));
            end
            2: begin
                it.fade_near = 20'd0;
                it.fade_far = 20'($urandom_range(4000, 1));
            end
            default: begin
                it.fade_near = 20'($urandom_range(3000));
                it.fade_far = 20'($urandom_range(4000));
            end
        endcase
        return it;
    endfunction

    task automatic test_rejects();
        t_in_item it;
        send_item(make_cmd(CMD_CLEAR));
        it = make_light(16'd0, 3);
        it.light_radius = 0;
        send_item(it);
        it = make_light(16'd0, 3);
        it.base_intensity = 0;
        it.light_radius = 14'h3FFF;
        send_item(it);
        send_item(make_cmd(CMD_COLLECT));
        send_item(make_cmd(CMD_UNUSED));
    endtask

    task automatic test_fade_cases();
        t_in_item it;
        send_item(make_cmd(CMD_CLEAR));
        // disabled, far zero, swap, zero start, equal distances, zero weight, full weight far off
        it = make_light(16'd0, 1);
        it.fade_near = 1;
        it.fade_far = 1;
        send_item(it);
        it = make_light(16'd0, 0);
        it.fade_far = 0;
        it.fade_near = 20'hFFFFF;
        send_item(it);
        it = make_light(16'd0, 3);
        it.fade_near = 3000;
        it.fade_far = 500;
        send_item(it);
        it = make_light(16'd0, 2);
        send_item(it);
        it = make_light(16'd0, 3);
        it.fade_near = 1500;
        it.fade_far = 1500;
        send_item(it);
        it = make_light(16'd0, 3);
        it.style_weight = 0;
        send_item(it);
        it = make_light(16'd0, 3);
        it.base_intensity = 16'hFFFF;
        it.style_weight = 16'hFFFF;
        it.fade_far = 0;
        it.pos_x = 20'h80000;
        it.pos_y = 20'h7FFFF;
        it.pos_z = 20'h80000;
        send_item(it);
        send_item(make_cmd(CMD_COLLECT));
    endtask

    task automatic test_owner_replace();
        send_item(make_cmd(CMD_CLEAR));
        send_item(make_light(16'hFFFF, 3));
        send_item(make_light(16'd7, 3));
        send_item(make_light(16'hFFFF, 1));
        send_item(make_light(16'd0, 2));
        send_item(make_cmd(CMD_COLLECT));
    endtask

    task automatic test_limits();
        drain();
        write_reg(REG_MAX_SEL, 20'd0);
        send_item(make_cmd(CMD_COLLECT));
        drain();
        write_reg(REG_MAX_SEL, 20'd127);
        send_item(make_cmd(CMD_COLLECT));
        drain();
        write_reg(REG_MAX_SEL, 20'd1);
        send_item(make_cmd(CMD_COLLECT));
        drain();
        write_reg(REG_VIEW_X, 20'h80000);
        write_reg(REG_VIEW_Y, 20'h7FFFF);
        write_reg(REG_VIEW_Z, 20'h80000);
        write_reg(REG_MAX_SEL, 20'd64);
        send_item(make_cmd(CMD_COLLECT));
    endtask

    task automatic test_full_table();
        send_item(make_cmd(CMD_CLEAR));
        for (int i = 0; i < DEPTH + 3; i++) begin
            t_in_item it;
            it = make_light(16'(i + 1), $urandom_range(3));
            it.light_radius = 14'd1;
            it.base_intensity = 16'($urandom_range(65535, 1));
            send_item(it);
        end
        send_item(make_light(16'd5, 3));
        send_item(make_cmd(CMD_COLLECT));
    endtask

    task automatic test_backpressure();
        send_item(make_cmd(CMD_CLEAR));
        for (int i = 0; i < 10; i++) send_item(make_light(16'($urandom_range(3)), 3));
        hold_left = 600;
        send_item(make_cmd(CMD_COLLECT));
        send_item(make_light(16'd0, 2));
        send_item(make_cmd(CMD_COLLECT));
        drain();
    endtask

    task automatic random_phase(int count);
        int stop;
        int pick;
        stop = sent + count;
        while (sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(make_cmd(CMD_CLEAR));
            end else if (pick < 14) begin
                t_in_item it;
                it = t_in_item'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom}));
                send_item(it);
            end else begin
                int n;
                n = $urandom_range(12, 1);
                for (int i = 0; i < n; i++)
                    send_item(make_light(16'($urandom_range(6)), $urandom_range(3)));
                send_item(make_cmd(CMD_COLLECT));
            end
        end
    endtask

    task automatic test_random();
        send_idle_pct = 37;
        recv_idle_pct = 70;
        random_phase(20);
        drain();
        write_reg(REG_VIEW_X, 20'($urandom));
        write_reg(REG_VIEW_Y, 20'($urandom));
        write_reg(REG_VIEW_Z, 20'($urandom));
        write_reg(REG_MAX_SEL, 20'($urandom_range(8, 1)));
        send_idle_pct = 70;
        recv_idle_pct = 37;
        random_phase(20);
        drain();
        write_reg(REG_VIEW_X, 20'd0);
        write_reg(REG_VIEW_Y, 20'd0);
        write_reg(REG_VIEW_Z, 20'd0);
        write_reg(REG_MAX_SEL, 20'd64);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(20);
    endtask

    initial begin
        errors = 0;
        sent = 0;
        hold_left = 0;
        send_idle_pct = 37;
        recv_idle_pct = 70;
        light_total = 0;
        select_limit = MAX_SEL_RESET;
        for (int k = 0; k < 3; k++) viewer[k] = '0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_rejects();
        test_fade_cases();
        test_owner_replace();
        test_limits();
        test_full_table();
        drain();
        write_reg(REG_VIEW_X, 20'h7FFFF);
        write_reg(REG_VIEW_Y, 20'h80000);
        write_reg(REG_VIEW_Z, 20'h7FFFF);
        test_backpressure();
        test_random();

        drain();
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
